/* hdl/lllt_pkg.sv */
`default_nettype none

package lllt_pkg;

    // request codes
    localparam logic [1:0] CMD_CHECK = 2'd0;
    localparam logic [1:0] CMD_INC   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // verdict codes
    localparam logic [1:0] VERDICT_OK    = 2'd0;
    localparam logic [1:0] VERDICT_LONG  = 2'd1;
    localparam logic [1:0] VERDICT_SHORT = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_EN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREEZE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_SECS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_SECS = 3'd4;

    // configuration reset values and count limit
    localparam logic [7:0]  RST_THRESHOLD  = 8'd3;
    localparam logic [15:0] RST_LONG_SECS  = 16'd900;
    localparam logic [7:0]  RST_SHORT_SECS = 8'd15;
    localparam logic [7:0]  COUNT_MAX      = 8'd255;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] client_ip;
        logic [63:0] account_key;
        logic [31:0] now_seconds;
    } t_req;

    typedef struct packed {
        logic [1:0] verdict;
        logic       hit;
    } t_rsp;

    typedef struct packed {
        logic        short_lock_enable;
        logic        count_freeze;
        logic [7:0]  error_threshold;
        logic [15:0] long_lock_seconds;
        logic [7:0]  short_lock_seconds;
    } t_cfg;

endpackage

`default_nettype wire

/* hdl/lru_login_lockout_table.sv */
// Failed-login lockout table with least-recently-used replacement. A check
// request looks up the client IP and account key across TABLE_ENTRIES entries
// held in flip-flops, all compared in parallel; it reports whether the entry
// was found and whether a long or short lock is active, and a miss takes over
// a free entry or the least recent one. Increment and clear requests act on
// the most recent entry. One request is taken every clock cycle while the
// input register is not stalled; each one is held in the input register,
// the lookup runs while it is held there, and the table update and the
// load of its result into the output register happen together when it
// moves on. A stalled result holds the request behind it in the input
// register. The table update between those two registers sets the cycle
// time. Configuration registers are written through a plain write port.
`default_nettype none

module lru_login_lockout_table
    import lllt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 3
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // request channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_req                  i_in_data,
    // result channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_rsp                       o_out_data,
    // configuration write port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;
    logic r_in_valid;
    t_req r_in;
    logic r_out_valid;
    t_rsp r_out;
    t_rsp rsp;
    logic out_free;
    logic advance;
    logic accept;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_lock_enable  <= 1'b1;
            r_cfg.count_freeze       <= 1'b0;
            r_cfg.error_threshold    <= RST_THRESHOLD;
            r_cfg.long_lock_seconds  <= RST_LONG_SECS;
            r_cfg.short_lock_seconds <= RST_SHORT_SECS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SHORT_EN:   r_cfg.short_lock_enable  <= i_cfg_data[0];
                CFG_FREEZE:     r_cfg.count_freeze       <= i_cfg_data[0];
                CFG_THRESHOLD:  r_cfg.error_threshold    <= i_cfg_data[7:0];
                CFG_LONG_SECS:  r_cfg.long_lock_seconds  <= i_cfg_data[15:0];
                CFG_SHORT_SECS: r_cfg.short_lock_seconds <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // handshake: a held request moves on when the output register is free
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign accept     = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in_data;
        end
    end

    // lookup and update
    lllt_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_req_valid(advance),
        .i_req      (r_in),
        .o_rsp      (rsp)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

/* hdl/lllt_table.sv */
`default_nettype none

module lllt_table
    import lllt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 3
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_req_valid,
    input  wire t_req i_req,
    output t_rsp      o_rsp
);

    localparam int IdxW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int RankW = IdxW;
    localparam logic [RankW-1:0] RankLast = RankW'(TABLE_ENTRIES - 1);

    // entry storage
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [RankW-1:0]         r_rank  [TABLE_ENTRIES];
    logic [7:0]               r_count [TABLE_ENTRIES];
    logic [31:0]              r_ip    [TABLE_ENTRIES];
    logic [63:0]              r_acct  [TABLE_ENTRIES];
    logic [31:0]              r_time  [TABLE_ENTRIES];

    logic [TABLE_ENTRIES-1:0] match;
    logic [TABLE_ENTRIES-1:0] bump;
    logic                     hit;
    logic [IdxW-1:0]          sel_idx;
    logic                     free_any;
    logic [IdxW-1:0]          free_idx;
    logic [IdxW-1:0]          old_idx;
    logic                     front_any;
    logic [IdxW-1:0]          front_idx;
    logic [IdxW-1:0]          ins_idx;
    logic [RankW-1:0]         sel_rank;
    logic [7:0]               sel_count;
    logic [32:0]              age;
    logic                     age_neg;
    logic                     in_long;
    logic                     in_short;
    logic [1:0]               verdict;

    // parallel compare and priority picks
    always_comb begin
        hit       = 1'b0;
        sel_idx   = '0;
        free_any  = 1'b0;
        free_idx  = '0;
        old_idx   = '0;
        front_any = 1'b0;
        front_idx = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            match[i] = r_valid[i] && (r_ip[i] == i_req.client_ip)
                       && (r_acct[i] == i_req.account_key);
            if (!hit && match[i]) begin
                hit     = 1'b1;
                sel_idx = IdxW'(i);
            end
            if (!free_any && !r_valid[i]) begin
                free_any = 1'b1;
                free_idx = IdxW'(i);
            end
            if (r_valid[i] && r_rank[i] == RankLast) begin
                old_idx = IdxW'(i);
            end
            if (!front_any && r_valid[i] && r_rank[i] == '0) begin
                front_any = 1'b1;
                front_idx = IdxW'(i);
            end
        end
    end

    assign ins_idx   = free_any ? free_idx : old_idx;
    assign sel_rank  = r_rank[sel_idx];
    assign sel_count = r_count[sel_idx];

    // entries that move back one place in recency order
    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (hit) begin
                bump[i] = r_valid[i] && (IdxW'(i) != sel_idx) && (r_rank[i] < sel_rank);
            end else begin
                bump[i] = r_valid[i] && (IdxW'(i) != ins_idx);
            end
        end
    end

    // lock windows, a negative age is inside any window
    assign age      = {1'b0, i_req.now_seconds} - {1'b0, r_time[sel_idx]};
    assign age_neg  = age[32];
    assign in_long  = age_neg || (age[31:0] <= {16'd0, i_cfg.long_lock_seconds});
    assign in_short = age_neg || (age[31:0] <= {24'd0, i_cfg.short_lock_seconds});

    always_comb begin
        verdict = VERDICT_OK;
        if (hit) begin
            if (sel_count >= i_cfg.error_threshold) begin
                if (in_long) begin
                    verdict = VERDICT_LONG;
                end
            end else if (sel_count != 8'd0 && i_cfg.short_lock_enable) begin
                if (in_short) begin
                    verdict = VERDICT_SHORT;
                end
            end
        end
    end

    // result for the request
    always_comb begin
        o_rsp = '0;
        if (i_req.cmd == CMD_CHECK) begin
            o_rsp.verdict = verdict;
            o_rsp.hit     = hit;
        end
    end

    // control state: valid, recency and counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                r_rank[i]  <= '0;
                r_count[i] <= '0;
            end
        end else if (i_req_valid) begin
            unique case (i_req.cmd)
                CMD_CHECK: begin
                    for (int i = 0; i < TABLE_ENTRIES; i++) begin
                        if (bump[i]) begin
                            r_rank[i] <= r_rank[i] + 1'b1;
                        end
                    end
                    if (hit) begin
                        r_rank[sel_idx] <= '0;
                    end else begin
                        r_valid[ins_idx] <= 1'b1;
                        r_rank[ins_idx]  <= '0;
                        r_count[ins_idx] <= '0;
                    end
                end
                CMD_INC: begin
                    if (!i_cfg.count_freeze && front_any
                        && r_count[front_idx] != COUNT_MAX) begin
                        r_count[front_idx] <= r_count[front_idx] + 8'd1;
                    end
                end
                CMD_CLEAR: begin
                    if (front_any) begin
                        r_count[front_idx] <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // payload storage, written on fill and on time stamps
    always_ff @(posedge i_clk) begin
        if (i_req_valid) begin
            unique case (i_req.cmd)
                CMD_CHECK: begin
                    if (!hit) begin
                        r_ip[ins_idx]   <= i_req.client_ip;
                        r_acct[ins_idx] <= i_req.account_key;
                        r_time[ins_idx] <= i_req.now_seconds;
                    end
                end
                CMD_INC: begin
                    if (!i_cfg.count_freeze && front_any) begin
                        r_time[front_idx] <= i_req.now_seconds;
                    end
                end
                CMD_CLEAR: begin
                    if (front_any) begin
                        r_time[front_idx] <= i_req.now_seconds;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire
